// File: src/linear_diophantine_solver_defines.svh
// Assertion macros shared by the solver's RTL files.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef LINEAR_DIOPHANTINE_SOLVER_DEFINES_SVH
`define LINEAR_DIOPHANTINE_SOLVER_DEFINES_SVH

// Implication that must hold at every clock edge outside reset.
`define LDS_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define LDS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lds_pkg.sv
// Package for the linear Diophantine solver: widths, sequencer states and
// shared types. No dependencies.
`timescale 1ns / 1ps
package lds_pkg;
  localparam int DataWidthDefault = 32;
  localparam int MagW = 33;   // magnitude of a DATA_WIDTH value, DW <= 32
  localparam int CoefW = 64;  // Bezout coefficients and results
  localparam int ProdW = 2 * MagW;  // full product of two MagW-bit signed operands

  typedef enum logic [3:0] {
    ST_IDLE, ST_ZERO, ST_CHECK, ST_DIV_START, ST_DIV_WAIT, ST_UPD_S,
    ST_UPD_T, ST_FDIV_START, ST_FDIV_WAIT, ST_MUL_X, ST_MUL_Y, ST_OUT
  } state_t;

  // Divider request handed from the sequencer.
  typedef struct packed {
    logic           start;
    logic [MagW-1:0] dividend;
    logic [MagW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [MagW-1:0] quot;
    logic [MagW-1:0] rem;
  } div_rsp_t;
endpackage

// File: src/lds_divider.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on lds_pkg.
`timescale 1ns / 1ps
module lds_divider (
  input  logic              clk,
  input  logic              rst,
  input  lds_pkg::div_req_t req,
  output lds_pkg::div_rsp_t rsp
);
  import lds_pkg::*;
  `include "linear_diophantine_solver_defines.svh"

  localparam int CntW = $clog2(MagW + 1);

  logic [MagW-1:0] rem;
  logic [MagW-1:0] quot;
  logic [MagW-1:0] dsr;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic            done;
  logic [MagW:0]   trial;

  assign trial = {rem, quot[MagW-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        quot <= req.dividend;
        dsr  <= req.divisor;
        cnt  <= CntW'(MagW);
      end else if (busy) begin
        if (trial[MagW]) begin
          rem  <= {rem[MagW-2:0], quot[MagW-1]};
          quot <= {quot[MagW-2:0], 1'b0};
        end else begin
          rem  <= trial[MagW-1:0];
          quot <= {quot[MagW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

  `LDS_ASSERT_NEXT(a_done_after_busy, clk, rst, busy && cnt == CntW'(1) && !req.start,
    done, "divider did not finish")
  `LDS_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy || $past(req.start),
    "divider done while busy")
endmodule

// File: src/linear_diophantine_solver.sv
// Top level of the linear Diophantine solver: sequencer, Euclid registers
// and multiplier around one shared divider. Depends on lds_pkg, lds_divider.
//
// Usage: an item on the s_axis channel carries a, b and c (tdata, a in the
// lowest 32 bits). The block runs the extended Euclidean algorithm on |a|
// and |b|. Each remainder step passes a compare state, a start state and a
// wait on the shared radix-2 divider, then ST_UPD_S and ST_UPD_T update the
// Bezout coefficients. At most about 46 steps, then one more division of c
// by g and, when g divides c, the multiplications for x and y. One item is
// worked on at a time: s_axis_tready is high only while the sequencer is
// idle. The result waits in the output register on m_axis until taken;
// while the receiver stalls the block holds it there, and the next item may
// be taken in and worked on, but its result waits until the register frees.
// Reset clears the sequencer and the output valid; no payload is cleared.
// When a and b are both zero the answer is given at once: solvable only if
// c is zero, with g, x and y all zero.
`timescale 1ns / 1ps
module linear_diophantine_solver #(
  parameter int DATA_WIDTH = lds_pkg::DataWidthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // coef_a[31:0], coef_b[63:32], rhs_c[95:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata   // solvable[0], divisor_g[31:1],
                                      // sol_x[95:32], sol_y[159:96]
);
  import lds_pkg::*;
  `include "linear_diophantine_solver_defines.svh"

  state_t state, state_next;

  // Sign-extended operands from the low DATA_WIDTH bits of each field.
  logic signed [MagW-1:0] a_in, b_in, c_in;
  assign a_in = MagW'(signed'(s_axis_tdata[DATA_WIDTH-1:0]));
  assign b_in = MagW'(signed'(s_axis_tdata[32+DATA_WIDTH-1:32]));
  assign c_in = MagW'(signed'(s_axis_tdata[64+DATA_WIDTH-1:64]));

  logic              neg_a, neg_b, neg_c;
  logic [MagW-1:0]   c_mag;
  logic [MagW-1:0]   r0, r1;
  logic signed [CoefW-1:0] s0, s1, t0, t1;
  logic [MagW-1:0]   k;
  logic signed [CoefW-1:0] f;
  logic              ok;
  logic signed [CoefW-1:0] x_res, y_res;

  div_req_t dreq;
  div_rsp_t drsp;

  lds_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Shared multiplier: k * coefficient, or coefficient * f. The Bezout
  // coefficients, k and f all stay within 2^31 in magnitude, so MagW-bit
  // signed operands suffice and the product never exceeds 2^62.
  logic signed [MagW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_a = s1[MagW-1:0];
    mul_b = signed'(k);
    case (state)
      ST_UPD_T: mul_a = t1[MagW-1:0];
      ST_MUL_X: begin mul_a = s0[MagW-1:0]; mul_b = f[MagW-1:0]; end
      ST_MUL_Y: begin mul_a = t0[MagW-1:0]; mul_b = f[MagW-1:0]; end
      default: mul_a = s1[MagW-1:0];
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid) begin
        if (a_in == '0 && b_in == '0) state_next = ST_ZERO;
        else state_next = ST_CHECK;
      end
      ST_ZERO: if (m_axis_tready || !m_axis_tvalid) state_next = ST_IDLE;
      ST_CHECK: state_next = (r1 == '0) ? ST_FDIV_START : ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (drsp.done) state_next = ST_UPD_S;
      ST_UPD_S: state_next = ST_UPD_T;
      ST_UPD_T: state_next = ST_CHECK;
      ST_FDIV_START: state_next = ST_FDIV_WAIT;
      ST_FDIV_WAIT: if (drsp.done) state_next = drsp.rem == '0 ? ST_MUL_X : ST_OUT;
      ST_MUL_X: state_next = ST_MUL_Y;
      ST_MUL_Y: state_next = ST_OUT;
      ST_OUT: if (m_axis_tready || !m_axis_tvalid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dreq.start    = (state == ST_DIV_START) || (state == ST_FDIV_START);
    dreq.dividend = (state == ST_FDIV_START) ? c_mag : r0;
    dreq.divisor  = (state == ST_FDIV_START) ? r0 : r1;
    s_axis_tready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Output holding register; loaded when the result is ready and the
  // previous one has been taken.
  logic load_out;
  assign load_out = (state == ST_OUT || state == ST_ZERO) &&
                    (m_axis_tready || !m_axis_tvalid);

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (load_out) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == ST_ZERO) begin
        m_axis_tdata <= {128'd0, 31'd0, c_mag == '0};
      end else begin
        m_axis_tdata <= {ok ? y_res : 64'sd0, ok ? x_res : 64'sd0,
                         r0[30:0], ok};
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (s_axis_tvalid) begin
        neg_a <= a_in[MagW-1];
        neg_b <= b_in[MagW-1];
        neg_c <= c_in[MagW-1];
        r0 <= a_in[MagW-1] ? -a_in : a_in;
        r1 <= b_in[MagW-1] ? -b_in : b_in;
        c_mag <= c_in[MagW-1] ? -c_in : c_in;
        s0 <= 64'sd1; s1 <= 64'sd0;
        t0 <= 64'sd0; t1 <= 64'sd1;
        ok <= 1'b0;
      end
      ST_DIV_WAIT: if (drsp.done) begin
        k  <= drsp.quot;
        r0 <= r1;
        r1 <= drsp.rem;
      end
      ST_UPD_S: begin
        s0 <= s1;
        s1 <= s0 - mul_p[CoefW-1:0];
      end
      ST_UPD_T: begin
        t0 <= t1;
        t1 <= t0 - mul_p[CoefW-1:0];
      end
      ST_FDIV_WAIT: if (drsp.done) begin
        ok <= (drsp.rem == '0);
        f  <= neg_c ? -CoefW'(drsp.quot) : CoefW'(drsp.quot);
      end
      ST_MUL_X: x_res <= neg_a ? -mul_p[CoefW-1:0] : mul_p[CoefW-1:0];
      ST_MUL_Y: y_res <= neg_b ? -mul_p[CoefW-1:0] : mul_p[CoefW-1:0];
      default: ;
    endcase
  end

  `LDS_ASSERT_IMP(a_ready_idle, clk, rst, s_axis_tready, state == ST_IDLE,
    "ready outside idle")
  `LDS_ASSERT_NEXT(a_hold_stall, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")
  `LDS_ASSERT_IMP(a_euclid_nonzero, clk, rst, state == ST_DIV_START, r1 != '0,
    "division by zero remainder")
endmodule

// File: sim/linear_diophantine_solver_tb.sv
// Self-checking testbench for linear_diophantine_solver: directed and random a, b, c items
// with an in-bench extended Euclid predictor. Depends on the RTL and lds_pkg only.
`timescale 1ns / 1ps
module linear_diophantine_solver_tb;

  localparam int DW = 32;
  localparam longint CycleLimit = 2_000_000;

  typedef struct packed {
    logic [63:0] y;
    logic [63:0] x;
    logic [30:0] g;
    logic        ok;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;

  answer_t answers_due[$];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      mismatches = 0;
  int      answers_seen = 0;
  int      items_sent = 0;
  int      solvable_seen = 0;
  longint  cycles = 0;

  linear_diophantine_solver #(.DATA_WIDTH(DW)) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #1 clk = ~clk;

  // Extended Euclid on the magnitudes, then scaling by c/g with sign fix-up.
  function automatic answer_t solve_equation(logic [31:0] ra, logic [31:0] rb,
                                             logic [31:0] rc);
    longint a, b, c, r0, r1, s0, s1, t0, t1, k, tmp, f;
    answer_t ans;
    a = longint'(signed'(ra));
    b = longint'(signed'(rb));
    c = longint'(signed'(rc));
    ans = '0;
    r0 = (a < 0) ? -a : a;
    r1 = (b < 0) ? -b : b;
    if (r0 == 0 && r1 == 0) begin
      ans.ok = (c == 0);
      return ans;
    end
    s0 = 1; s1 = 0; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      k = r0 / r1;
      tmp = r0 - k * r1; r0 = r1; r1 = tmp;
      tmp = s0 - k * s1; s0 = s1; s1 = tmp;
      tmp = t0 - k * t1; t0 = t1; t1 = tmp;
    end
    ans.g = r0[30:0];
    ans.ok = (c % r0) == 0;
    if (ans.ok) begin
      f = c / r0;
      ans.x = (a < 0) ? -(s0 * f) : s0 * f;
      ans.y = (b < 0) ? -(t0 * f) : t0 * f;
    end
    return ans;
  endfunction

  // Sends one item; the expectation is queued when the handshake completes.
  // Valid stays high after the handshake until the next item or an idle
  // cycle replaces it at the following falling edge.
  task automatic send_equation(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c, b, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    answers_due.insert(answers_due.size(), solve_equation(a, b, c));
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    answer_t got, want;
    cycles++;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = answer_t'(m_axis_tdata);
      answers_seen++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: %h", m_axis_tdata);
      end else begin
        want = answers_due.pop_front();
        if (got.ok) solvable_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: ok %b/%b g %0d/%0d x %0d/%0d y %0d/%0d (expected/actual)",
                     want.ok, got.ok, want.g, got.g, signed'(want.x), signed'(got.x),
                     signed'(want.y), signed'(got.y));
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("linear_diophantine_solver_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom_range(20);
      1: return -$urandom_range(20);
      2: return $urandom_range(5000) * 6;
      3: return 32'h8000_0000 | $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] edge_vals [8] = '{32'd0, 32'd1, -32'd1, 32'h7fff_ffff, 32'h8000_0001,
                                   32'h8000_0000, 32'd240, -32'd46};
    send_equation(0, 0, 0);            // both zero, c zero
    send_equation(0, 0, 5);            // both zero, c non-zero
    send_equation(6, 0, 12);           // b zero
    send_equation(0, -6, 12);          // a zero, negative b
    send_equation(4, 6, 7);            // not solvable
    send_equation(-4, 6, -10);         // negative a
    send_equation(32'h8000_0000, 32'h8000_0000, 0); // g reaches 2^31
    send_equation(32'h8000_0000, 0, 32'h8000_0000);
    send_equation(1836311903, 1134903170, 32'h7fff_ffff); // long Fibonacci run
    send_equation(-1836311903, -1134903170, 32'h8000_0001);
    for (int i = 0; i < 8; i++)
      send_equation(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8]);
    send_equation(32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random(int count);
    logic [31:0] a, b, c;
    for (int i = 0; i < count; i++) begin
      a = pick_value();
      b = pick_value();
      // Half the items are scaled so that g divides c.
      c = ($urandom_range(1)) ? a * $urandom_range(50) - b * $urandom_range(50)
                              : pick_value();
      send_equation(a, b, c);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 6; recv_idle_pct = 74;
    test_directed();
    test_random(100);
    send_idle_pct = 74; recv_idle_pct = 6;
    test_random(100);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(100);
    wait_drained();
    $display("Sent %0d equations, %0d answers checked, %0d solvable.",
             items_sent, answers_seen, solvable_seen);
    if (mismatches == 0) $display("linear_diophantine_solver_tb: PASS");
    else $display("linear_diophantine_solver_tb: FAIL");
    $finish;
  end

endmodule
